@@ design/gpnms_pkg.sv @@
`default_nettype none
package gpnms_pkg;

	// threshold register width and reset value (1.0 squared, 8 fractional bits)
	localparam int THRESH_BITS = 34;
	localparam logic [THRESH_BITS-1:0] THRESH_RESET = 34'd256;

	// control flags that travel with a point from cell to cell
	typedef struct packed {
		logic active;   // slot carries a point
		logic last;     // final point of its set
		logic supp;     // suppressed by a stored point upstream
		logic stored;   // already captured by a cell upstream
	} tok_ctl_t;

	localparam tok_ctl_t TOK_IDLE = '{active: 1'b0, last: 1'b0, supp: 1'b0, stored: 1'b0};

endpackage
`default_nettype wire

@@ design/gpnms_ifs.sv @@
`default_nettype none
interface gpnms_pt_if #(
	parameter int COORD_BITS = 16
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] coord_z;
	logic [COORD_BITS-1:0] coord_y;
	logic [COORD_BITS-1:0] coord_x;
	logic                  last_point;

	modport source (output valid, coord_z, coord_y, coord_x, last_point, input ready);
	modport sink   (input valid, coord_z, coord_y, coord_x, last_point, output ready);
endinterface

interface gpnms_res_if;
	logic valid;
	logic ready;
	logic keep;
	logic store_full;
	logic set_done;

	modport source (output valid, keep, store_full, set_done, input ready);
	modport sink   (input valid, keep, store_full, set_done, output ready);
endinterface

interface gpnms_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [gpnms_pkg::THRESH_BITS-1:0] radius_sq;

	modport source (output valid, radius_sq, input ready);
	modport sink   (input valid, radius_sq, output ready);
endinterface
`default_nettype wire

@@ design/gpnms_cell.sv @@
`default_nettype none
module gpnms_cell #(
	parameter int COORD_BITS = 16
) (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   en,
	input  wire  [gpnms_pkg::THRESH_BITS-1:0]     thresh,
	input  gpnms_pkg::tok_ctl_t                   in_ctl,
	input  wire  [2:0][COORD_BITS-1:0]            in_pt,
	output gpnms_pkg::tok_ctl_t                   out_ctl,
	output logic [2:0][COORD_BITS-1:0]            out_pt
);
	import gpnms_pkg::*;

	localparam int SQ_BITS  = 2 * COORD_BITS;
	localparam int SUM_BITS = SQ_BITS + 2;
	localparam int CMP_BITS = (SUM_BITS > THRESH_BITS) ? SUM_BITS : THRESH_BITS;

	// held point
	logic                       occ_q;
	logic [2:0][COORD_BITS-1:0] pt_q;

	// first half: squared differences
	tok_ctl_t                   ctl_s1;
	logic [2:0][COORD_BITS-1:0] pt_s1;
	logic                       cmp_s1;
	logic [2:0][SQ_BITS-1:0]    sq_s1;

	// second half: sum and compare
	tok_ctl_t                   ctl_s2;
	logic [2:0][COORD_BITS-1:0] pt_s2;

	logic                       free_tok;
	logic                       cap;
	logic                       cmp;
	logic [2:0][COORD_BITS-1:0] diff;
	logic [2:0][SQ_BITS-1:0]    sq;
	logic [SUM_BITS-1:0]        dsum;
	logic                       hit;
	tok_ctl_t                   ctl_mid;
	tok_ctl_t                   ctl_fin;

	always_comb begin
		free_tok = in_ctl.active & ~in_ctl.supp & ~in_ctl.stored;
		cap      = free_tok & ~occ_q;
		cmp      = free_tok & occ_q;
		for (int d = 0; d < 3; d++) begin
			diff[d] = (pt_q[d] >= in_pt[d]) ? (pt_q[d] - in_pt[d]) : (in_pt[d] - pt_q[d]);
			sq[d]   = {{COORD_BITS{1'b0}}, diff[d]} * {{COORD_BITS{1'b0}}, diff[d]};
		end
		ctl_mid        = in_ctl;
		ctl_mid.stored = in_ctl.stored | cap;
	end

	always_comb begin
		dsum = {2'b00, sq_s1[0]} + {2'b00, sq_s1[1]} + {2'b00, sq_s1[2]};
		hit  = cmp_s1 &&
			(CMP_BITS'(dsum) < CMP_BITS'(thresh));
		ctl_fin      = ctl_s1;
		ctl_fin.supp = ctl_s1.supp | hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= 1'b0;
			ctl_s1 <= TOK_IDLE;
			cmp_s1 <= 1'b0;
			ctl_s2 <= TOK_IDLE;
		end else if (en) begin
			// the last point of a set empties the cell behind it
			if (in_ctl.active && in_ctl.last) begin
				occ_q <= 1'b0;
			end else if (cap) begin
				occ_q <= 1'b1;
			end
			ctl_s1 <= ctl_mid;
			cmp_s1 <= cmp;
			ctl_s2 <= ctl_fin;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (cap) begin
				pt_q <= in_pt;
			end
			pt_s1 <= in_pt;
			sq_s1 <= sq;
			pt_s2 <= pt_s1;
		end
	end

	assign out_ctl = ctl_s2;
	assign out_pt  = pt_s2;

endmodule
`default_nettype wire

@@ design/greedy_point_nms_3d.sv @@
// channel  | role   | carries
// ---------+--------+-----------------------------------------------------
// points   | sink   | coord_z, coord_y, coord_x (12.4 unsigned), last_point
// results  | source | keep, store_full, set_done, one per point, in order
// cfg      | sink   | radius_sq (34 bits, 8 fractional bits)
//
// one point transfer per cycle while results do not stall; between its point
// transfer and its result lie two stages in each of the MAX_KEPT comparator
// cells plus the result register, the first cell stage loading at the transfer
// reset empties every cell and sets the threshold to 256 (1.0 squared)
// a stall on results freezes the whole chain; points.ready follows it
// cfg is always ready
`default_nettype none
module greedy_point_nms_3d #(
	parameter int MAX_KEPT   = 64,
	parameter int COORD_BITS = 16
) (
	input wire clk,
	input wire arst_n,
	gpnms_pt_if.sink    points,
	gpnms_res_if.source results,
	gpnms_cfg_if.sink   cfg
);
	import gpnms_pkg::*;

	// suppression threshold
	logic [THRESH_BITS-1:0] thresh_q;

	// output register
	logic out_valid_q;
	logic keep_q;
	logic full_q;
	logic done_q;

	// chain advances whenever the output register is empty or being drained
	logic en;

	// taps between cells: index 0 feeds the first cell, MAX_KEPT leaves the last
	tok_ctl_t                   ctl_c [MAX_KEPT+1];
	logic [2:0][COORD_BITS-1:0] pt_c  [MAX_KEPT+1];

	assign en           = ~out_valid_q | results.ready;
	assign points.ready = en;
	assign cfg.ready    = 1'b1;

	// point entering the chain, nothing suppressed or stored yet
	always_comb begin
		ctl_c[0]        = TOK_IDLE;
		ctl_c[0].active = points.valid & en;
		ctl_c[0].last   = points.last_point;
		pt_c[0][0]      = points.coord_z;
		pt_c[0][1]      = points.coord_y;
		pt_c[0][2]      = points.coord_x;
	end

	// each cell holds at most one kept point; cells fill in order, so the
	// first free cell a surviving point reaches is the next store slot
	for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
		gpnms_cell #(
			.COORD_BITS(COORD_BITS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.thresh  (thresh_q),
			.in_ctl  (ctl_c[i]),
			.in_pt   (pt_c[i]),
			.out_ctl (ctl_c[i+1]),
			.out_pt  (pt_c[i+1])
		);
	end

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid) begin
			thresh_q <= cfg.radius_sq;
		end
	end

	// result register; a surviving point that found no free cell is flagged full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= ctl_c[MAX_KEPT].active;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			keep_q <= ~ctl_c[MAX_KEPT].supp;
			full_q <= ~ctl_c[MAX_KEPT].supp & ~ctl_c[MAX_KEPT].stored;
			done_q <= ctl_c[MAX_KEPT].last;
		end
	end

	assign results.valid      = out_valid_q;
	assign results.keep       = keep_q;
	assign results.store_full = full_q;
	assign results.set_done   = done_q;

	// coordinates leaving the last cell are not needed
	logic unused_pt;
	assign unused_pt = ^pt_c[MAX_KEPT];

endmodule
`default_nettype wire

@@ bench/tb.sv @@
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gpnms_pkg::*;

	localparam int MAX_KEPT       = 64;
	localparam int COORD_BITS     = 16;
	localparam int LATENCY        = 2 * MAX_KEPT;
	// the limit sits well above the long hold-off, so it leaves a wide margin
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 600;
	localparam int NUM_PHASES     = 12;

	typedef bit [COORD_BITS-1:0] coord_t;

	// one verdict as the block reports it
	typedef struct packed {
		bit keep;
		bit store_full;
		bit set_done;
	} verdict_t;

	// tracks the store of kept points and queues the verdict for each point
	class suppression_tracker;
		bit [THRESH_BITS-1:0] radius_sq;
		coord_t               kept_pts [MAX_KEPT][3];
		int                   kept_cnt;
		verdict_t             pending_verdicts [$];
		int                   errors;

		function new();
			radius_sq = THRESH_RESET;
			kept_cnt  = 0;
			errors    = 0;
		endfunction

		// judge an accepted point against every stored point of its set
		function void note_point(coord_t z, coord_t y, coord_t x, bit last);
			verdict_t        v;
			coord_t          pt [3];
			coord_t          diff;
			longint unsigned acc;
			longint unsigned dd;
			pt[0] = z;
			pt[1] = y;
			pt[2] = x;
			v.keep       = 1'b1;
			v.store_full = 1'b0;
			v.set_done   = last;
			for (int i = 0; i < kept_cnt; i++) begin
				acc = 0;
				for (int d = 0; d < 3; d++) begin
					diff = (kept_pts[i][d] >= pt[d]) ? kept_pts[i][d] - pt[d]
						: pt[d] - kept_pts[i][d];
					dd   = 64'(diff);
					acc  = acc + dd * dd;
				end
				if (acc < 64'(radius_sq)) begin
					v.keep = 1'b0;
					break;
				end
			end
			if (v.keep) begin
				if (kept_cnt < MAX_KEPT) begin
					for (int d = 0; d < 3; d++)
						kept_pts[kept_cnt][d] = pt[d];
					kept_cnt++;
				end else begin
					// kept but no room left, later points skip it
					v.store_full = 1'b1;
				end
			end
			if (last)
				kept_cnt = 0;
			pending_verdicts.push_back(v);
		endfunction

		function void check_verdict(bit keep, bit store_full, bit set_done);
			verdict_t exp_v;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result with nothing pending, actual keep %0b full %0b done %0b",
					$time, keep, store_full, set_done);
				errors++;
				return;
			end
			exp_v = pending_verdicts.pop_front();
			if (keep !== exp_v.keep) begin
				$display("%0t: keep mismatch, expected %0b actual %0b",
					$time, exp_v.keep, keep);
				errors++;
			end
			if (store_full !== exp_v.store_full) begin
				$display("%0t: store_full mismatch, expected %0b actual %0b",
					$time, exp_v.store_full, store_full);
				errors++;
			end
			if (set_done !== exp_v.set_done) begin
				$display("%0t: set_done mismatch, expected %0b actual %0b",
					$time, exp_v.set_done, set_done);
				errors++;
			end
		endfunction

		function int pending();
			return pending_verdicts.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	suppression_tracker tracker;

	// set by the stimulus when the receiver should hold off for a long stretch
	bit hold_req = 1'b0;

	int idle_cycles = 0;
	int burst_left  = 0;

	gpnms_pt_if #(.COORD_BITS(COORD_BITS)) pt_ch ();
	gpnms_res_if res_ch ();
	gpnms_cfg_if cfg_ch ();

	greedy_point_nms_3d #(
		.MAX_KEPT  (MAX_KEPT),
		.COORD_BITS(COORD_BITS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.points (pt_ch),
		.results(res_ch),
		.cfg    (cfg_ch)
	);

	// 4 ns period
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// monitors: values are sampled at the edge, before the edge's updates land
	always @(posedge clk) begin
		if (arst_n) begin
			// note the point before checking, so a same-edge result sees older points only
			if (pt_ch.valid && pt_ch.ready)
				tracker.note_point(pt_ch.coord_z, pt_ch.coord_y, pt_ch.coord_x,
					pt_ch.last_point);
			if (res_ch.valid && res_ch.ready)
				tracker.check_verdict(res_ch.keep, res_ch.store_full, res_ch.set_done);
			if (cfg_ch.valid && cfg_ch.ready)
				tracker.radius_sq = cfg_ch.radius_sq;
		end
	end

	// watchdog: cycles in a row with no transfer on any channel
	always @(posedge clk) begin
		if (arst_n) begin
			if ((pt_ch.valid && pt_ch.ready) || (res_ch.valid && res_ch.ready)
					|| (cfg_ch.valid && cfg_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// receiver: runs of free flow, light and heavy stalls, and one long hold-off
	initial begin
		int run_len;
		int mode;
		bit held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				// hold off long enough for the chain to fill and stall the points
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				run_len = $urandom_range(1, 60);
				mode    = $urandom_range(0, 2);
				for (int i = 0; i < run_len; i++) begin
					case (mode)
						0: begin
							res_ch.ready <= 1'b1;
						end
						1: begin
							res_ch.ready <= ($urandom_range(0, 1) == 0);
						end
						default: begin
							res_ch.ready <= ($urandom_range(0, 4) != 0);
						end
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// offer one point; bursts of random length with random gaps between them
	task automatic offer_point(coord_t z, coord_t y, coord_t x, bit last);
		int gap;
		if (burst_left == 0) begin
			// a quarter of the bursts follow on with no gap at all
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				pt_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		pt_ch.valid      <= 1'b1;
		pt_ch.coord_z    <= z;
		pt_ch.coord_y    <= y;
		pt_ch.coord_x    <= x;
		pt_ch.last_point <= last;
		do
			@(posedge clk);
		while (!pt_ch.ready);
	endtask

	// lower valid after the last transfer and wait for every verdict
	task automatic drain_results();
		pt_ch.valid <= 1'b0;
		burst_left = 0;
		while (tracker.pending() != 0)
			@(posedge clk);
	endtask

	// threshold write, only while the chain is empty
	task automatic write_radius(bit [THRESH_BITS-1:0] value);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.radius_sq <= value;
		do
			@(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// random sets: clusters around a center with a per-set spread, plus noise
	task automatic run_random_phase(int n_items);
		int     left;
		int     set_len;
		int     shift;
		coord_t cz, cy, cx;
		coord_t pz, py, px;
		bit     last;
		left = n_items;
		while (left > 0) begin
			// mostly short sets, now and then one long enough to fill the store
			set_len = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 90)
				: $urandom_range(1, 24);
			if (set_len > left)
				set_len = left;
			cz    = COORD_BITS'($urandom);
			cy    = COORD_BITS'($urandom);
			cx    = COORD_BITS'($urandom);
			shift = $urandom_range(0, 12);
			for (int k = 0; k < set_len; k++) begin
				if ($urandom_range(0, 6) == 0) begin
					// noise point anywhere in the cube
					pz = COORD_BITS'($urandom);
					py = COORD_BITS'($urandom);
					px = COORD_BITS'($urandom);
				end else begin
					pz = cz + COORD_BITS'($urandom_range(0, 1 << shift));
					py = cy + COORD_BITS'($urandom_range(0, 1 << shift));
					px = cx + COORD_BITS'($urandom_range(0, 1 << shift));
				end
				// a stray end marker now and then breaks a set early
				last = (k == set_len - 1) || ($urandom_range(0, 39) == 0);
				offer_point(pz, py, px, last);
				left--;
			end
		end
	endtask

	// main sequence
	initial begin
		bit [THRESH_BITS-1:0] radius;
		tracker = new();
		arst_n           <= 1'b0;
		pt_ch.valid      <= 1'b0;
		pt_ch.coord_z    <= '0;
		pt_ch.coord_y    <= '0;
		pt_ch.coord_x    <= '0;
		pt_ch.last_point <= 1'b0;
		cfg_ch.valid     <= 1'b0;
		cfg_ch.radius_sq <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset threshold 1.0 squared: distance exactly at the radius keeps
		offer_point(16'd0, 16'd0, 16'd0, 1'b0);
		offer_point(16'd0, 16'd0, 16'd16, 1'b0);
		offer_point(16'd0, 16'd0, 16'd15, 1'b0);
		offer_point(16'hffff, 16'hffff, 16'hffff, 1'b0);
		offer_point(16'hffff, 16'hffff, 16'hfff0, 1'b0);
		offer_point(16'hffff, 16'd0, 16'hffff, 1'b0);
		offer_point(16'd0, 16'hffff, 16'd0, 1'b1);
		// store cleared at end of set, so this one is kept again
		offer_point(16'd0, 16'd0, 16'd15, 1'b1);
		drain_results();

		// largest threshold: even opposite corners suppress
		write_radius('1);
		offer_point(16'd0, 16'd0, 16'd0, 1'b0);
		offer_point(16'hffff, 16'hffff, 16'hffff, 1'b0);
		offer_point(16'hffff, 16'd0, 16'd0, 1'b1);
		drain_results();

		// zero threshold: duplicates all survive
		write_radius('0);
		offer_point(16'd4660, 16'd4660, 16'd4660, 1'b0);
		offer_point(16'd4660, 16'd4660, 16'd4660, 1'b0);
		offer_point(16'd4660, 16'd4660, 16'd4660, 1'b1);
		drain_results();

		// threshold one: a duplicate is suppressed, a neighbor one step away is not
		write_radius(34'd1);
		offer_point(16'd100, 16'd200, 16'd300, 1'b0);
		offer_point(16'd100, 16'd200, 16'd300, 1'b0);
		offer_point(16'd100, 16'd200, 16'd301, 1'b1);
		drain_results();

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: radius = '0;
				1: radius = 34'd1024;
				2: radius = '1;
				3: radius = 34'd1;
				4: radius = THRESH_RESET;
				default: begin
					radius = ($urandom_range(0, 3) == 0)
						? THRESH_BITS'({$urandom, $urandom})
						: THRESH_BITS'($urandom_range(0, 1 << 20));
				end
			endcase
			write_radius(radius);
			if (p == 1)
				hold_req = 1'b1;
			run_random_phase((p == 1) ? 200 : 150);
			drain_results();
		end

		// anything arriving now is unexpected
		repeat (2 * LATENCY) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

@@ sim.f @@
design/gpnms_pkg.sv
design/gpnms_ifs.sv
design/gpnms_cell.sv
design/greedy_point_nms_3d.sv
bench/tb.sv
